### rtl/core/hep_pkg.sv
// Shared types and constants for the Heston path step block.
// Used by hep_mul, hep_sqrt and heston_euler_path_step; depends on nothing.
package hep_pkg;

    // Signed working word, 32 fraction bits unless noted.
    typedef logic signed [63:0] hep_word_t;

    // Request to the shared multiplier; sel28 picks a 28-bit scale instead of 32.
    typedef struct packed {
        logic      valid;
        logic      sel28;
        hep_word_t a;
        hep_word_t b;
    } mul_req_t;

    // Request to the shared square root unit.
    typedef struct packed {
        logic        valid;
        logic [39:0] x;
    } sqrt_req_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STEP_SIZE   = 3'd0;
    localparam logic [2:0] REG_REVERSION   = 3'd1;
    localparam logic [2:0] REG_LONG_RUN    = 3'd2;
    localparam logic [2:0] REG_VOL_OF_VOL  = 3'd3;
    localparam logic [2:0] REG_CORRELATION = 3'd4;
    localparam logic [2:0] REG_DRIFT       = 3'd5;
    localparam logic [2:0] REG_INIT_PRICE  = 3'd6;
    localparam logic [2:0] REG_INIT_VAR    = 3'd7;

    // Register reset values.
    localparam logic [32:0] RST_STEP_SIZE   = 33'd17043521;
    localparam logic [39:0] RST_REVERSION   = 40'd6442450944;
    localparam logic [35:0] RST_LONG_RUN    = 36'd171798692;
    localparam logic [35:0] RST_VOL_OF_VOL  = 36'd1288490189;
    localparam logic [33:0] RST_CORRELATION = 34'h34CCCCCCD;
    localparam logic [35:0] RST_DRIFT       = 36'd214748365;
    localparam logic [47:0] RST_INIT_PRICE  = 48'd429496729600;
    localparam logic [35:0] RST_INIT_VAR    = 36'd171798692;

    // Arithmetic limits.
    localparam hep_word_t   ONE_Q32   = 64'sh0000_0001_0000_0000;
    localparam hep_word_t   VAR_FLOOR = 64'sd43;
    localparam hep_word_t   VAR_MAX   = 64'sh0000_000F_FFFF_FFFF;
    localparam hep_word_t   PRICE_MAX = 64'sh0000_FFFF_FFFF_FFFF;
    localparam logic [61:0] MAG_CAP   = 62'h2000_0000_0000_0000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

### rtl/core/heston_euler_path_step.sv
// Top level of the Heston path step: configuration registers, path state and
// the sequencer over the shared multiplier and square root. Depends on hep_pkg,
// hep_mul and hep_sqrt.
//
// Use: the input channel (in_valid/in_ready) takes one word holding restart and
// two Q4.28 normal samples; the output channel (out_valid/out_ready) returns one
// word per input with the new price, variance and step index.
// A restart word reloads the initial price and variance and goes straight to
// the finish state without using the shared units. A normal step runs 17
// operations in sequence on the shared units: 13 multiplies and 4 square
// roots; the square root unit, one bit per cycle, takes the larger share of
// the time. in_ready is high only while no word is in work.
// The output register holds a finished word until it is taken, and the next
// input word may be accepted and worked on meanwhile; a stall on the output
// delays only the completion of that next word.
// Configuration goes through the APB port, registers at byte address 8*i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset loads the register defaults, sets price and
// variance to the default initial values and clears the count.
module heston_euler_path_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    input  logic signed [31:0] variance_noise,
    input  logic signed [31:0] price_noise,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [47:0]        price,
    output logic [35:0]        variance,
    output logic [15:0]        step_index
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Operation sequence of one step.
    localparam logic [4:0] OP_SQRT_DT  = 5'd0;
    localparam logic [4:0] OP_DZ2      = 5'd1;
    localparam logic [4:0] OP_DW       = 5'd2;
    localparam logic [4:0] OP_REV      = 5'd3;
    localparam logic [4:0] OP_REV_DT   = 5'd4;
    localparam logic [4:0] OP_SQRT_V   = 5'd5;
    localparam logic [4:0] OP_XI_SV    = 5'd6;
    localparam logic [4:0] OP_VAR_DIFF = 5'd7;
    localparam logic [4:0] OP_RHO_SQ   = 5'd8;
    localparam logic [4:0] OP_SQRT_C   = 5'd9;
    localparam logic [4:0] OP_RHO_DZ2  = 5'd10;
    localparam logic [4:0] OP_C_DW     = 5'd11;
    localparam logic [4:0] OP_MU_S     = 5'd12;
    localparam logic [4:0] OP_DRIFT_DT = 5'd13;
    localparam logic [4:0] OP_SQRT_VN  = 5'd14;
    localparam logic [4:0] OP_SV_S     = 5'd15;
    localparam logic [4:0] OP_PRICE    = 5'd16;

    // Configuration registers.
    logic [32:0] step_size_reg;
    logic [39:0] reversion_rate_reg;
    logic [35:0] long_run_variance_reg;
    logic [35:0] vol_of_vol_reg;
    logic [33:0] correlation_reg;
    logic [35:0] drift_reg;
    logic [47:0] initial_price_reg;
    logic [35:0] initial_variance_reg;

    // Path state and sequencer.
    logic [1:0]  state_reg;
    logic [4:0]  op_reg;
    logic [47:0] cur_price_reg;
    logic [35:0] cur_var_reg;
    logic [15:0] count_reg;

    // Working values of one step.
    hep_pkg::hep_word_t zv_reg, zp_reg, rho_reg, sdt_reg, dz2_reg, dw_reg;
    hep_pkg::hep_word_t ta_reg, t1_reg, sv_reg, ub_reg, rr_reg, sc_reg;
    hep_pkg::hep_word_t p1_reg, dz1_reg, m_reg, t2_reg, svn_reg, cc_reg;

    // Output register.
    logic        out_valid_reg;
    logic [47:0] price_reg;
    logic [35:0] variance_reg;
    logic [15:0] step_index_reg;

    hep_pkg::mul_req_t  mul_req;
    hep_pkg::sqrt_req_t sq_req;
    logic               mul_done;
    hep_pkg::hep_word_t mul_res;
    logic               sq_done;
    logic [35:0]        sq_root;
    hep_pkg::hep_word_t sq_res;

    hep_pkg::hep_word_t s_ext, v_ext, dt_ext, corr_ext, rho_next;
    hep_pkg::hep_word_t vsum, vclamp, psum, pclamp, c_arg;
    logic               is_sqrt_op;
    logic               unit_done;
    logic               in_fire;
    logic               cfg_write;

    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == ST_IDLE);
    assign pready    = 1'b1;

    hep_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    hep_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Extended views of state and registers, and the clamped correlation.
    always_comb
    begin
        s_ext    = $signed({16'd0, cur_price_reg});
        v_ext    = $signed({28'd0, cur_var_reg});
        dt_ext   = $signed({31'd0, step_size_reg});
        sq_res   = $signed({28'd0, sq_root});
        corr_ext = $signed({{30{correlation_reg[33]}}, correlation_reg});
        if (corr_ext > hep_pkg::ONE_Q32)
        begin
            rho_next = hep_pkg::ONE_Q32;
        end
        else if (corr_ext < -hep_pkg::ONE_Q32)
        begin
            rho_next = -hep_pkg::ONE_Q32;
        end
        else
        begin
            rho_next = corr_ext;
        end
        c_arg = hep_pkg::ONE_Q32 - rr_reg;
    end

    // New variance and price with their limits.
    always_comb
    begin
        vsum = v_ext + t1_reg + mul_res;
        if (vsum < hep_pkg::VAR_FLOOR)
        begin
            vclamp = hep_pkg::VAR_FLOOR;
        end
        else if (vsum > hep_pkg::VAR_MAX)
        begin
            vclamp = hep_pkg::VAR_MAX;
        end
        else
        begin
            vclamp = vsum;
        end
        psum = s_ext + t2_reg + mul_res;
        if (psum < 64'sd0)
        begin
            pclamp = 64'sd0;
        end
        else if (psum > hep_pkg::PRICE_MAX)
        begin
            pclamp = hep_pkg::PRICE_MAX;
        end
        else
        begin
            pclamp = psum;
        end
    end

    // Operand selection for the operation being issued.
    always_comb
    begin
        mul_req    = '0;
        sq_req     = '0;
        is_sqrt_op = (op_reg == OP_SQRT_DT) || (op_reg == OP_SQRT_V) ||
                     (op_reg == OP_SQRT_C) || (op_reg == OP_SQRT_VN);
        if (state_reg == ST_ISSUE)
        begin
            case (op_reg)
                OP_SQRT_DT:  sq_req = '{valid: 1'b1, x: {7'd0, step_size_reg}};
                OP_DZ2:      mul_req = '{1'b1, 1'b1, zv_reg, sdt_reg};
                OP_DW:       mul_req = '{1'b1, 1'b1, zp_reg, sdt_reg};
                OP_REV:      mul_req = '{1'b1, 1'b0, $signed({24'd0, reversion_rate_reg}),
                                         $signed({28'd0, long_run_variance_reg}) - v_ext};
                OP_REV_DT:   mul_req = '{1'b1, 1'b0, ta_reg, dt_ext};
                OP_SQRT_V:   sq_req = '{valid: 1'b1, x: {4'd0, cur_var_reg}};
                OP_XI_SV:    mul_req = '{1'b1, 1'b0, $signed({28'd0, vol_of_vol_reg}), sv_reg};
                OP_VAR_DIFF: mul_req = '{1'b1, 1'b0, ub_reg, dz2_reg};
                OP_RHO_SQ:   mul_req = '{1'b1, 1'b0, rho_reg, rho_reg};
                OP_SQRT_C:   sq_req = '{valid: 1'b1, x: c_arg[39:0]};
                OP_RHO_DZ2:  mul_req = '{1'b1, 1'b0, rho_reg, dz2_reg};
                OP_C_DW:     mul_req = '{1'b1, 1'b0, sc_reg, dw_reg};
                OP_MU_S:     mul_req = '{1'b1, 1'b0,
                                         $signed({{28{drift_reg[35]}}, drift_reg}), s_ext};
                OP_DRIFT_DT: mul_req = '{1'b1, 1'b0, m_reg, dt_ext};
                OP_SQRT_VN:  sq_req = '{valid: 1'b1, x: {4'd0, cur_var_reg}};
                OP_SV_S:     mul_req = '{1'b1, 1'b0, svn_reg, s_ext};
                OP_PRICE:    mul_req = '{1'b1, 1'b0, cc_reg, dz1_reg};
                default:     mul_req = '0;
            endcase
        end
        unit_done = is_sqrt_op ? sq_done : mul_done;
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg         <= hep_pkg::RST_STEP_SIZE;
            reversion_rate_reg    <= hep_pkg::RST_REVERSION;
            long_run_variance_reg <= hep_pkg::RST_LONG_RUN;
            vol_of_vol_reg        <= hep_pkg::RST_VOL_OF_VOL;
            correlation_reg       <= hep_pkg::RST_CORRELATION;
            drift_reg             <= hep_pkg::RST_DRIFT;
            initial_price_reg     <= hep_pkg::RST_INIT_PRICE;
            initial_variance_reg  <= hep_pkg::RST_INIT_VAR;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                hep_pkg::REG_STEP_SIZE:   step_size_reg         <= pwdata[32:0];
                hep_pkg::REG_REVERSION:   reversion_rate_reg    <= pwdata[39:0];
                hep_pkg::REG_LONG_RUN:    long_run_variance_reg <= pwdata[35:0];
                hep_pkg::REG_VOL_OF_VOL:  vol_of_vol_reg        <= pwdata[35:0];
                hep_pkg::REG_CORRELATION: correlation_reg       <= pwdata[33:0];
                hep_pkg::REG_DRIFT:       drift_reg             <= pwdata[35:0];
                hep_pkg::REG_INIT_PRICE:  initial_price_reg     <= pwdata[47:0];
                hep_pkg::REG_INIT_VAR:    initial_variance_reg  <= pwdata[35:0];
                default:                  step_size_reg         <= step_size_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[5:3])
            hep_pkg::REG_STEP_SIZE:   prdata = {31'd0, step_size_reg};
            hep_pkg::REG_REVERSION:   prdata = {24'd0, reversion_rate_reg};
            hep_pkg::REG_LONG_RUN:    prdata = {28'd0, long_run_variance_reg};
            hep_pkg::REG_VOL_OF_VOL:  prdata = {28'd0, vol_of_vol_reg};
            hep_pkg::REG_CORRELATION: prdata = {30'd0, correlation_reg};
            hep_pkg::REG_DRIFT:       prdata = {28'd0, drift_reg};
            hep_pkg::REG_INIT_PRICE:  prdata = {16'd0, initial_price_reg};
            hep_pkg::REG_INIT_VAR:    prdata = {28'd0, initial_variance_reg};
            default:                  prdata = 64'd0;
        endcase
    end

    // Sequencer, path state and write back of unit results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SQRT_DT;
            cur_price_reg <= hep_pkg::RST_INIT_PRICE;
            cur_var_reg   <= hep_pkg::RST_INIT_VAR;
            count_reg     <= 16'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (restart)
                        begin
                            cur_price_reg <= initial_price_reg;
                            cur_var_reg   <= initial_variance_reg;
                            count_reg     <= 16'd0;
                            state_reg     <= ST_FINISH;
                        end
                        else
                        begin
                            op_reg    <= OP_SQRT_DT;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        if (op_reg == OP_VAR_DIFF)
                        begin
                            cur_var_reg <= vclamp[35:0];
                        end
                        if (op_reg == OP_PRICE)
                        begin
                            cur_price_reg <= pclamp[47:0];
                            if (count_reg != hep_pkg::COUNT_MAX)
                            begin
                                count_reg <= count_reg + 16'd1;
                            end
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            op_reg    <= op_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers of one step.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            zv_reg  <= $signed({{32{variance_noise[31]}}, variance_noise});
            zp_reg  <= $signed({{32{price_noise[31]}}, price_noise});
            rho_reg <= rho_next;
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (op_reg)
                OP_SQRT_DT:  sdt_reg <= sq_res;
                OP_DZ2:      dz2_reg <= mul_res;
                OP_DW:       dw_reg  <= mul_res;
                OP_REV:      ta_reg  <= mul_res;
                OP_REV_DT:   t1_reg  <= mul_res;
                OP_SQRT_V:   sv_reg  <= sq_res;
                OP_XI_SV:    ub_reg  <= mul_res;
                OP_RHO_SQ:   rr_reg  <= mul_res;
                OP_SQRT_C:   sc_reg  <= sq_res;
                OP_RHO_DZ2:  p1_reg  <= mul_res;
                OP_C_DW:     dz1_reg <= p1_reg + mul_res;
                OP_MU_S:     m_reg   <= mul_res;
                OP_DRIFT_DT: t2_reg  <= mul_res;
                OP_SQRT_VN:  svn_reg <= sq_res;
                OP_SV_S:     cc_reg  <= mul_res;
                default:     cc_reg  <= cc_reg;
            endcase
        end
    end

    // Output register: holds a finished word until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            price_reg      <= 48'd0;
            variance_reg   <= 36'd0;
            step_index_reg <= 16'd0;
        end
        else
        begin
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg  <= 1'b1;
                price_reg      <= cur_price_reg;
                variance_reg   <= cur_var_reg;
                step_index_reg <= count_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign price      = price_reg;
    assign variance   = variance_reg;
    assign step_index = step_index_reg;

    // The sequencer never starts both shared units in the same cycle.
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_req.valid && sq_req.valid))
        else $error("multiplier and square root started together");

    // An accepted word always moves the sequencer out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted word left the sequencer idle");

    // A multiplier result only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier result arrived outside the wait state");

endmodule

### rtl/core/hep_mul.sv
// Shared fixed-point multiplier: exact 64x64 product from four 32x32 partials,
// then rounded, scaled and saturated. Depends on hep_pkg.
module hep_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  hep_pkg::mul_req_t   req,
    output logic                done,
    output hep_pkg::hep_word_t  result
);

    localparam logic [2:0] PH_ROUND = 3'd5;

    logic               busy_reg;
    logic [2:0]         phase_reg;
    logic [63:0]        ma_reg;
    logic [63:0]        mb_reg;
    logic               neg_reg;
    logic               sh28_reg;
    logic [63:0]        prod_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    hep_pkg::hep_word_t result_reg;

    logic [63:0]        a_mag;
    logic [63:0]        b_mag;
    logic [31:0]        a_part;
    logic [31:0]        b_part;
    logic [127:0]       add_term;
    logic [127:0]       q;
    logic               over;
    logic [61:0]        mag;
    hep_pkg::hep_word_t result_next;

    // Operand magnitudes and the partial product selection.
    always_comb
    begin
        a_mag  = req.a[63] ? (~req.a + 64'd1) : req.a;
        b_mag  = req.b[63] ? (~req.b + 64'd1) : req.b;
        a_part = phase_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_part = phase_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    end

    // Alignment of the partial product registered in the previous cycle.
    always_comb
    begin
        case (phase_reg)
            3'd1:    add_term = {64'd0, prod_reg};
            3'd2:    add_term = {32'd0, prod_reg, 32'd0};
            3'd3:    add_term = {32'd0, prod_reg, 32'd0};
            3'd4:    add_term = {prod_reg, 64'd0};
            default: add_term = 128'd0;
        endcase
    end

    // Scale, saturate the magnitude and restore the sign.
    always_comb
    begin
        q    = sh28_reg ? (acc_reg >> 28) : (acc_reg >> 32);
        over = (|q[127:62]) || (q[61] && (|q[60:0]));
        mag  = over ? hep_pkg::MAG_CAP : q[61:0];
        result_next = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    // Sequencing of the partial products and the rounding step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            phase_reg  <= 3'd0;
            ma_reg     <= 64'd0;
            mb_reg     <= 64'd0;
            neg_reg    <= 1'b0;
            sh28_reg   <= 1'b0;
            prod_reg   <= 64'd0;
            acc_reg    <= 128'd0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.valid)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 3'd0;
                ma_reg    <= a_mag;
                mb_reg    <= b_mag;
                neg_reg   <= req.a[63] ^ req.b[63];
                sh28_reg  <= req.sel28;
                // The rounding constant seeds the accumulator.
                acc_reg   <= req.sel28 ? (128'd1 << 27) : (128'd1 << 31);
            end
            else if (busy_reg)
            begin
                if (phase_reg < 3'd4)
                begin
                    prod_reg <= a_part * b_part;
                end
                if (phase_reg != 3'd0 && phase_reg < PH_ROUND)
                begin
                    acc_reg <= acc_reg + add_term;
                end
                if (phase_reg == PH_ROUND)
                begin
                    result_reg <= result_next;
                    done_reg   <= 1'b1;
                    busy_reg   <= 1'b0;
                end
                phase_reg <= phase_reg + 3'd1;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/hep_sqrt.sv
// Shared square root unit: floor(sqrt(x * 2^32)), one root bit per cycle.
// Depends on hep_pkg.
module hep_sqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  hep_pkg::sqrt_req_t req,
    output logic               done,
    output logic [35:0]        root
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [71:0] rad_reg;
    logic [39:0] rem_reg;
    logic [35:0] root_reg;
    logic        done_reg;

    logic [39:0] rem_cat;
    logic [39:0] trial;
    logic        fits;

    // One restoring step: bring down a pair of bits and try the next root bit.
    always_comb
    begin
        rem_cat = {rem_reg[37:0], rad_reg[71:70]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = rem_cat >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            rad_reg  <= 72'd0;
            rem_reg  <= 40'd0;
            root_reg <= 36'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.valid)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                rad_reg  <= {req.x, 32'd0};
                rem_reg  <= 40'd0;
                root_reg <= 36'd0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[69:0], 2'b00};
                rem_reg  <= fits ? (rem_cat - trial) : rem_cat;
                root_reg <= {root_reg[34:0], fits};
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd35)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### tb/testbench.sv
// Testbench for heston_euler_path_step: a cycle-free model of one Euler step
// predicts every output word, and a checker compares the words as they leave.
// Depends on hep_pkg and the RTL of the block.
module testbench;

    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [127:0] MAG_LIMIT = 128'h2000_0000_0000_0000;

    typedef struct packed {
        logic [47:0] price;
        logic [35:0] variance;
        logic [15:0] step_index;
    } path_point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               restart = 1'b0;
    logic signed [31:0] variance_noise = '0;
    logic signed [31:0] price_noise = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [47:0]        price;
    logic [35:0]        variance;
    logic [15:0]        step_index;

    // Model copy of the registers and the path state.
    logic [32:0] m_dt;
    logic [39:0] m_kappa;
    logic [35:0] m_theta;
    logic [35:0] m_xi;
    logic [33:0] m_rho;
    logic [35:0] m_mu;
    logic [47:0] m_s0;
    logic [35:0] m_v0;
    logic [47:0] m_price;
    logic [35:0] m_var;
    logic [15:0] m_count;

    path_point_t pending_points[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    heston_euler_path_step u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .variance_noise (variance_noise),
        .price_noise    (price_noise),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .price          (price),
        .variance       (variance),
        .step_index     (step_index)
    );

    always #5 clk = ~clk;

    // Product of two signed values scaled down by sh bits, rounded half away
    // from zero, magnitude capped at 2^61.
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
        input logic signed [63:0] b, input int sh);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  mag;
        ma = a[63] ? (~a + 64'd1) : a;
        mb = b[63] ? (~b + 64'd1) : b;
        p = {64'd0, ma} * {64'd0, mb};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        mag = (p > MAG_LIMIT) ? MAG_LIMIT[63:0] : p[63:0];
        return (a[63] != b[63]) ? -$signed(mag) : $signed(mag);
    endfunction

    // floor(sqrt(x * 2^32)) for x below 2^48, one result bit per pass.
    function automatic logic signed [63:0] root_q32(input logic [63:0] x);
        logic [79:0] n;
        logic [79:0] rem;
        logic [79:0] root;
        logic [79:0] trial;
        n = {x[47:0], 32'd0};
        rem = '0;
        root = '0;
        for (int i = 39; i >= 0; i--)
        begin
            rem = (rem << 2) | n[2*i +: 2];
            trial = (root << 2) | 80'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 80'd1;
            end
            else
                root = root << 1;
        end
        return $signed(root[63:0]);
    endfunction

    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
        input logic signed [63:0] lo, input logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advances the model path by one input word and returns the expected point.
    function automatic path_point_t advance_path(input logic rs, input logic signed [31:0] zv,
        input logic signed [31:0] zp);
        logic signed [63:0] dt, s, v, rho, mu, sdt, dz2, dw, t, u, vn, sc, dz1, sn;
        if (rs)
        begin
            m_price = m_s0;
            m_var = m_v0;
            m_count = '0;
        end
        else
        begin
            dt = $signed({31'd0, m_dt});
            s = $signed({16'd0, m_price});
            v = $signed({28'd0, m_var});
            rho = clamp_word({{30{m_rho[33]}}, m_rho}, -hep_pkg::ONE_Q32, hep_pkg::ONE_Q32);
            mu = {{28{m_mu[35]}}, m_mu};
            sdt = root_q32({31'd0, m_dt});
            dz2 = scaled_product(64'(zv), sdt, 28);
            dw = scaled_product(64'(zp), sdt, 28);
            t = scaled_product(scaled_product($signed({24'd0, m_kappa}),
                $signed({28'd0, m_theta}) - v, 32), dt, 32);
            u = scaled_product(scaled_product($signed({28'd0, m_xi}), root_q32(v), 32),
                dz2, 32);
            vn = clamp_word(v + t + u, hep_pkg::VAR_FLOOR, hep_pkg::VAR_MAX);
            sc = root_q32(hep_pkg::ONE_Q32 - scaled_product(rho, rho, 32));
            dz1 = scaled_product(rho, dz2, 32) + scaled_product(sc, dw, 32);
            t = scaled_product(scaled_product(mu, s, 32), dt, 32);
            u = scaled_product(scaled_product(root_q32(vn), s, 32), dz1, 32);
            sn = clamp_word(s + t + u, 64'sd0, hep_pkg::PRICE_MAX);
            m_price = sn[47:0];
            m_var = vn[35:0];
            if (m_count != hep_pkg::COUNT_MAX)
                m_count = m_count + 16'd1;
        end
        return '{price: m_price, variance: m_var, step_index: m_count};
    endfunction

    function automatic logic [63:0] register_mask(input logic [2:0] idx);
        case (idx)
            hep_pkg::REG_STEP_SIZE:   return (64'd1 << 33) - 1;
            hep_pkg::REG_REVERSION:   return (64'd1 << 40) - 1;
            hep_pkg::REG_CORRELATION: return (64'd1 << 34) - 1;
            hep_pkg::REG_INIT_PRICE:  return (64'd1 << 48) - 1;
            default:                  return (64'd1 << 36) - 1;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
        input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
            cycle_count);
        error_count++;
    endtask

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Output stalls: runs of free flow and of random backpressure in random order.
    initial
    begin
        int run;
        int mode;
        forever
        begin
            run = $urandom_range(5, 400);
            mode = $urandom_range(0, 3);
            repeat (run)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = ($urandom_range(0, 3) != 0);
                    2:       out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Checks each output word against the oldest expected point.
    always @(posedge clk)
    begin
        path_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                report_mismatch("unexpected word", {16'd0, price}, 64'd0);
            end
            else
            begin
                want = pending_points.pop_front();
                if (price !== want.price)
                    report_mismatch("price", price, want.price);
                if (variance !== want.variance)
                    report_mismatch("variance", variance, want.variance);
                if (step_index !== want.step_index)
                    report_mismatch("step_index", step_index, want.step_index);
            end
        end
    end

    // Register write through the APB port, then a read back.
    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] v;
        v = value & register_mask(idx);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if ((prdata & register_mask(idx)) !== v)
            report_mismatch("register read", prdata, v);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            hep_pkg::REG_STEP_SIZE:   m_dt = v[32:0];
            hep_pkg::REG_REVERSION:   m_kappa = v[39:0];
            hep_pkg::REG_LONG_RUN:    m_theta = v[35:0];
            hep_pkg::REG_VOL_OF_VOL:  m_xi = v[35:0];
            hep_pkg::REG_CORRELATION: m_rho = v[33:0];
            hep_pkg::REG_DRIFT:       m_mu = v[35:0];
            hep_pkg::REG_INIT_PRICE:  m_s0 = v[47:0];
            default:                  m_v0 = v[35:0];
        endcase
    endtask

    // Waits until the block has drained before a register write. The last
    // word has already been taken, so valid is dropped first.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_all(input logic [63:0] dt, input logic [63:0] kappa,
        input logic [63:0] theta, input logic [63:0] xi, input logic [63:0] rho,
        input logic [63:0] mu, input logic [63:0] s0, input logic [63:0] v0);
        wait_idle();
        write_register(hep_pkg::REG_STEP_SIZE, dt);
        write_register(hep_pkg::REG_REVERSION, kappa);
        write_register(hep_pkg::REG_LONG_RUN, theta);
        write_register(hep_pkg::REG_VOL_OF_VOL, xi);
        write_register(hep_pkg::REG_CORRELATION, rho);
        write_register(hep_pkg::REG_DRIFT, mu);
        write_register(hep_pkg::REG_INIT_PRICE, s0);
        write_register(hep_pkg::REG_INIT_VAR, v0);
    endtask

    // Sends one word; bursts of random length separated by random gaps.
    task automatic send_word(input logic rs, input logic signed [31:0] zv,
        input logic signed [31:0] zp);
        @(negedge clk);
        restart = rs;
        variance_noise = zv;
        price_noise = zp;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_points.push_back(advance_path(rs, zv, zp));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(1, 300)) @(negedge clk);
            end
        end
    endtask

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // Moderate Q4.28 normal sample, within about three sigma.
    function automatic logic signed [31:0] normal_sample();
        return $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000;
    endfunction

    task automatic test_reset_path();
        send_word(1'b0, 32'sd0, 32'sd0);
        send_word(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_word(1'b0, 32'sh1000_0000, 32'shF000_0000);
        send_word(1'b0, 32'sh8000_0000, 32'sh8000_0000);
    endtask

    task automatic test_extremes();
        // Correlation beyond one either way, initial values changed mid path.
        write_all(64'd17043521, 64'd6442450944, 64'd171798692, 64'd1288490189,
            64'h1_0000_0000 + 64'd5, 64'd214748365, 64'd429496729600, 64'd171798692);
        send_word(1'b0, 32'sh1000_0000, 32'sh1000_0000);
        write_all(64'd17043521, 64'd6442450944, 64'd171798692, 64'd1288490189,
            64'h2_0000_0000, -64'sd4294967296, 64'd1, 64'd0);
        send_word(1'b0, 32'sh1000_0000, 32'sh1000_0000);
        send_word(1'b1, 32'sd0, 32'sd0);
        send_word(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // Everything at maximum: price and variance saturate high.
        write_all(64'h1_0000_0000, 64'hFF_FFFF_FFFF, 64'hF_FFFF_FFFF, 64'hF_FFFF_FFFF,
            64'h1_0000_0000, 64'h7_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hF_FFFF_FFFF);
        send_word(1'b1, 32'sd0, 32'sd0);
        send_word(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_word(1'b0, 32'sh8000_0000, 32'sh8000_0000);
        send_word(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // Negative drift and anti-correlation: price and variance hit their floors.
        write_all(64'h1_0000_0000, 64'hFF_FFFF_FFFF, 64'd0, 64'hF_FFFF_FFFF,
            -64'sd4294967296, 64'h8_0000_0000, 64'hFFFF_FFFF_FFFF, 64'd43);
        send_word(1'b1, 32'sd0, 32'sd0);
        send_word(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // All registers zero.
        write_all(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_word(1'b1, 32'sd0, 32'sd0);
        send_word(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    endtask

    task automatic test_random_paths();
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase % 4 == 3)
                write_all(wide_random(), wide_random(), wide_random(), wide_random(),
                    wide_random(), wide_random(), wide_random(), wide_random());
            else
                write_all($urandom_range(32'h0010_0000, 32'h1000_0000),
                    $urandom_range(0, 32'h7FFF_FFFF) * 64'd8,
                    $urandom_range(32'h0100_0000, 32'h4000_0000),
                    $urandom_range(32'h0800_0000, 32'hC000_0000),
                    64'($signed($urandom_range(0, 32'hFFFF_FFFF)) >>> 0) * 2
                        - 64'h1_0000_0000,
                    64'($signed($urandom)),
                    {$urandom_range(1, 32'h0000_FFFF), $urandom},
                    $urandom_range(32'h0100_0000, 32'h8000_0000));
            send_word(1'b1, $urandom, $urandom);
            for (int k = 0; k < 44; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(1'b1, $urandom, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    send_word(1'b0, $urandom, $urandom);
                else
                    send_word(1'b0, normal_sample(), normal_sample());
            end
        end
    endtask

    initial
    begin
        m_dt = hep_pkg::RST_STEP_SIZE;
        m_kappa = hep_pkg::RST_REVERSION;
        m_theta = hep_pkg::RST_LONG_RUN;
        m_xi = hep_pkg::RST_VOL_OF_VOL;
        m_rho = hep_pkg::RST_CORRELATION;
        m_mu = hep_pkg::RST_DRIFT;
        m_s0 = hep_pkg::RST_INIT_PRICE;
        m_v0 = hep_pkg::RST_INIT_VAR;
        m_price = hep_pkg::RST_INIT_PRICE;
        m_var = hep_pkg::RST_INIT_VAR;
        m_count = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_path();
        test_extremes();
        test_random_paths();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

### files.f
rtl/core/hep_pkg.sv
rtl/core/hep_mul.sv
rtl/core/hep_sqrt.sv
rtl/core/heston_euler_path_step.sv
tb/testbench.sv
